### hdl/id3fte_pkg.sv
// id3fte_pkg: shared types, codes and helpers for the ID3v2 frame text extractor.
// Used by id3fte_parse, id3fte_outq and id3v2_frame_text_extractor. No dependencies.
package id3fte_pkg;

    localparam int unsigned HdrLen    = 10;
    localparam int unsigned MaxResult = 3;

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_FHDR = 2'd1,
        PH_PAY  = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        KIND_TAG_HDR   = 3'd0,
        KIND_FRM_BEGIN = 3'd1,
        KIND_TEXT      = 3'd2,
        KIND_FRM_END   = 3'd3,
        KIND_TAG_END   = 3'd4,
        KIND_NOT_FOUND = 3'd5
    } t_kind;

    typedef enum logic {
        CFG_MODE      = 1'b0,
        CFG_WANTED_ID = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] frame_id;
        logic [7:0]  text_char;
        logic [7:0]  major_version;
        logic [7:0]  revision;
        logic [7:0]  tag_flags;
        logic [27:0] tag_bytes;
    } t_result;

    // Up to three results caused by one byte, entry 0 first.
    typedef struct packed {
        logic [1:0]        cnt;
        t_result [2:0]     res;
    } t_bundle;

    function automatic t_result mk_result(t_kind kind, logic [31:0] fid, logic [7:0] ch,
                                          logic [7:0] maj, logic [7:0] rev,
                                          logic [7:0] flg, logic [27:0] sz);
        t_result r;
        r.kind          = kind;
        r.frame_id      = fid;
        r.text_char     = ch;
        r.major_version = maj;
        r.revision      = rev;
        r.tag_flags     = flg;
        r.tag_bytes     = sz;
        return r;
    endfunction

    // Letters, digits, space, dot, slash, comma.
    function automatic logic keep_char(logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h30 && b <= 8'h39) ||
               (b >= 8'h41 && b <= 8'h5a) || b == 8'h20 || b == 8'h2e ||
               b == 8'h2f || b == 8'h2c;
    endfunction

endpackage

### hdl/id3v2_frame_text_extractor.sv
// id3v2_frame_text_extractor: ID3v2 tag and frame header parser with text filter.
// Each byte is held in the input register, then its results in the result register.
// Throughput: one byte per cycle while the output is not stalled; a byte causing k
// results (k up to 3) holds the result register until the output port takes all k.
// Reset (synchronous, active low): parser waits for tag header byte 0, mode=list,
// wanted_id=0, no results pending. Depends on id3fte_pkg, id3fte_parse, id3fte_outq.
module id3v2_frame_text_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    // output word channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [31:0] o_frame_id,
    output logic [7:0]  o_text_char,
    output logic [7:0]  o_major_version,
    output logic [7:0]  o_revision,
    output logic [7:0]  o_tag_flags,
    output logic [27:0] o_tag_bytes,
    output logic        o_last,
    // configuration writes
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic                r_mode;
    logic [31:0]         r_wanted_id;

    logic                adv;
    logic                load;
    id3fte_pkg::t_bundle bundle;
    id3fte_pkg::t_result head;

    // Config registers: read live by the parser on every byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_wanted_id <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (id3fte_pkg::t_cfg_idx'(i_cfg_index))
                id3fte_pkg::CFG_MODE:      r_mode      <= i_cfg_data[0];
                id3fte_pkg::CFG_WANTED_ID: r_wanted_id <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register + parser state; builds all results of one byte at once.
    id3fte_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .i_mode       (r_mode),
        .i_wanted_id  (r_wanted_id),
        .i_adv        (adv),
        .o_load       (load),
        .o_bundle     (bundle)
    );

    // Result register: one word per cycle unless stalled; last flags the final one.
    id3fte_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_bundle    (bundle),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_head      (head),
        .o_last      (o_last)
    );

    assign o_kind          = head.kind;
    assign o_frame_id      = head.frame_id;
    assign o_text_char     = head.text_char;
    assign o_major_version = head.major_version;
    assign o_revision      = head.revision;
    assign o_tag_flags     = head.tag_flags;
    assign o_tag_bytes     = head.tag_bytes;

endmodule

### hdl/id3fte_parse.sv
// id3fte_parse: input word register, parser state and per-byte result builder.
// Depends on id3fte_pkg.
module id3fte_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_file_start,
    input  logic                i_mode,
    input  logic [31:0]         i_wanted_id,
    input  logic                i_adv,
    output logic                o_load,
    output id3fte_pkg::t_bundle o_bundle
);

    logic                 r_in_valid;
    logic [7:0]           r_byte;
    logic                 r_start;

    id3fte_pkg::t_phase   r_phase, n_phase;
    logic [3:0]           r_hidx, n_hidx;
    logic [31:0]          r_id, n_id;
    logic [31:0]          r_size, n_size;
    logic [23:0]          r_info, n_info;
    logic [27:0]          r_tag_len, n_tag_len;
    logic [31:0]          r_cons, n_cons;
    logic [31:0]          r_pay, n_pay;
    logic                 r_mact, n_mact;

    logic                 fire;
    logic                 fin, betw, tend;
    logic [1:0]           cnt;
    id3fte_pkg::t_result [2:0] res;

    function automatic logic [31:0] sat_add(logic [31:0] c, logic [3:0] k);
        logic [32:0] s;
        s = {1'b0, c} + {29'd0, k};
        return s[32] ? 32'hffff_ffff : s[31:0];
    endfunction

    assign fire       = r_in_valid && i_adv;
    assign o_in_stall = r_in_valid && !i_adv;
    assign o_load     = fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
        if (i_in_valid && !o_in_stall) begin
            r_byte  <= i_data_byte;
            r_start <= i_file_start;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_hidx    = r_hidx;
        n_id      = r_id;
        n_size    = r_size;
        n_info    = r_info;
        n_tag_len = r_tag_len;
        n_cons    = r_cons;
        n_pay     = r_pay;
        n_mact    = r_mact;
        fin       = 1'b0;
        betw      = 1'b0;
        tend      = 1'b0;
        cnt       = 2'd0;
        res       = '0;

        if (r_start) begin
            n_phase   = id3fte_pkg::PH_TAG;
            n_hidx    = 4'd0;
            n_id      = '0;
            n_size    = '0;
            n_info    = '0;
            n_tag_len = '0;
            n_cons    = '0;
            n_pay     = '0;
            n_mact    = 1'b0;
        end

        unique case (n_phase)
            id3fte_pkg::PH_TAG: begin
                if (n_hidx == 4'd0) begin
                    n_info = '0;
                    n_size = '0;
                end
                if (n_hidx == 4'd3) begin
                    n_info[23:16] = r_byte;
                end else if (n_hidx == 4'd4) begin
                    n_info[15:8] = r_byte;
                end else if (n_hidx == 4'd5) begin
                    n_info[7:0] = r_byte;
                end else if (n_hidx >= 4'd6) begin
                    // syncsafe: seven bits per byte, 28 bits kept
                    n_size = {4'd0, n_size[20:0], r_byte[6:0]};
                end
                if (n_hidx >= 4'(id3fte_pkg::HdrLen - 1)) begin
                    n_tag_len = n_size[27:0];
                    n_cons    = '0;
                    res[cnt]  = id3fte_pkg::mk_result(id3fte_pkg::KIND_TAG_HDR, 32'd0,
                                    8'd0, n_info[23:16], n_info[15:8], n_info[7:0],
                                    n_size[27:0]);
                    cnt       = cnt + 2'd1;
                    betw      = 1'b1;
                end
                n_hidx = n_hidx + 4'd1;
            end
            id3fte_pkg::PH_FHDR: begin
                if (n_hidx == 4'd0 && r_byte == 8'd0) begin
                    n_cons = sat_add(n_cons, 4'd1);
                    tend   = 1'b1;
                end else begin
                    if (n_hidx < 4'd4) begin
                        n_id = {n_id[23:0], r_byte};
                    end else if (n_hidx < 4'd8) begin
                        n_size = {n_size[23:0], r_byte};
                    end
                    if (n_hidx >= 4'(id3fte_pkg::HdrLen - 1)) begin
                        n_cons = sat_add(n_cons, 4'(id3fte_pkg::HdrLen));
                        n_pay  = n_size;
                        n_mact = 1'b0;
                        if (!i_mode || n_id == i_wanted_id) begin
                            n_mact   = i_mode;
                            res[cnt] = id3fte_pkg::mk_result(id3fte_pkg::KIND_FRM_BEGIN,
                                           n_id, 8'd0, 8'd0, 8'd0, 8'd0, 28'd0);
                            cnt      = cnt + 2'd1;
                        end
                        if (n_pay == 32'd0) begin
                            fin = 1'b1;
                        end else begin
                            n_phase = id3fte_pkg::PH_PAY;
                        end
                    end
                    n_hidx = n_hidx + 4'd1;
                end
            end
            id3fte_pkg::PH_PAY: begin
                n_cons = sat_add(n_cons, 4'd1);
                if (n_pay != 32'd0) begin
                    n_pay = n_pay - 32'd1;
                end
                if ((!i_mode || n_mact) && id3fte_pkg::keep_char(r_byte)) begin
                    res[cnt] = id3fte_pkg::mk_result(id3fte_pkg::KIND_TEXT, 32'd0,
                                   r_byte, 8'd0, 8'd0, 8'd0, 28'd0);
                    cnt      = cnt + 2'd1;
                end
                if (n_pay == 32'd0) begin
                    fin = 1'b1;
                end
            end
            id3fte_pkg::PH_DONE: begin
            end
            default: begin
            end
        endcase

        if (fin) begin
            if (!i_mode || n_mact) begin
                res[cnt] = id3fte_pkg::mk_result(id3fte_pkg::KIND_FRM_END, 32'd0,
                               8'd0, 8'd0, 8'd0, 8'd0, 28'd0);
                cnt      = cnt + 2'd1;
            end
            if (n_mact) begin
                n_mact  = 1'b0;
                n_phase = id3fte_pkg::PH_DONE;
            end else begin
                betw = 1'b1;
            end
        end

        if (betw) begin
            if (n_cons >= {4'd0, n_tag_len}) begin
                tend = 1'b1;
            end else begin
                n_phase = id3fte_pkg::PH_FHDR;
                n_hidx  = 4'd0;
                n_id    = '0;
                n_size  = '0;
            end
        end

        if (tend) begin
            res[cnt] = id3fte_pkg::mk_result(i_mode ? id3fte_pkg::KIND_NOT_FOUND :
                           id3fte_pkg::KIND_TAG_END, 32'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                           28'd0);
            cnt      = cnt + 2'd1;
            n_phase  = id3fte_pkg::PH_DONE;
        end
    end

    assign o_bundle.cnt = cnt;
    assign o_bundle.res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= id3fte_pkg::PH_TAG;
            r_hidx    <= '0;
            r_id      <= '0;
            r_size    <= '0;
            r_info    <= '0;
            r_tag_len <= '0;
            r_cons    <= '0;
            r_pay     <= '0;
            r_mact    <= 1'b0;
        end else if (fire) begin
            r_phase   <= n_phase;
            r_hidx    <= n_hidx;
            r_id      <= n_id;
            r_size    <= n_size;
            r_info    <= n_info;
            r_tag_len <= n_tag_len;
            r_cons    <= n_cons;
            r_pay     <= n_pay;
            r_mact    <= n_mact;
        end
    end

endmodule

### hdl/id3fte_outq.sv
// id3fte_outq: result register of one byte's results, one word a cycle unless stalled.
// Depends on id3fte_pkg.
module id3fte_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  id3fte_pkg::t_bundle i_bundle,
    output logic                o_adv,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output id3fte_pkg::t_result o_head,
    output logic                o_last
);

    logic [1:0]                r_left;
    id3fte_pkg::t_result [2:0] r_res;
    logic                      take;

    assign take        = o_out_valid && !i_out_stall;
    assign o_out_valid = r_left != 2'd0;
    // free for the next byte once the last held result leaves
    assign o_adv       = (r_left == 2'd0) || (r_left == 2'd1 && take);
    assign o_head      = r_res[0];
    assign o_last      = r_left == 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (i_load) begin
            r_left <= i_bundle.cnt;
        end else if (take) begin
            r_left <= r_left - 2'd1;
        end
        if (i_load) begin
            r_res <= i_bundle.res;
        end else if (take) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

endmodule

### verif/testbench.sv
// Self-checking testbench for id3v2_frame_text_extractor: streams ID3v2 tags
// byte by byte, predicts the result words in step, and checks them in order.
// Depends on id3fte_pkg and the block's RTL only.
module testbench;

    localparam int SettleCycles = 10;    // covers the input and result registers with margin
    localparam int QuietLimit   = 2000;  // cycles with no handshake before giving up

    // One byte of the file as the sender drives it.
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_in_word;

    // One result word plus its end-of-byte marker.
    typedef struct packed {
        id3fte_pkg::t_result res;
        logic                last;
    } t_out_word;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte  = '0;
    logic        i_file_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic [2:0]  o_kind;
    logic [31:0] o_frame_id;
    logic [7:0]  o_text_char;
    logic [7:0]  o_major_version;
    logic [7:0]  o_revision;
    logic [7:0]  o_tag_flags;
    logic [27:0] o_tag_bytes;
    logic        o_last;
    logic        i_cfg_wr_en  = 1'b0;
    logic [0:0]  i_cfg_index  = '0;
    logic [31:0] i_cfg_data   = '0;

    id3v2_frame_text_extractor u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_file_start    (i_file_start),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_frame_id      (o_frame_id),
        .o_text_char     (o_text_char),
        .o_major_version (o_major_version),
        .o_revision      (o_revision),
        .o_tag_flags     (o_tag_flags),
        .o_tag_bytes     (o_tag_bytes),
        .o_last          (o_last),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    t_in_word  pending_bytes[$];   // bytes waiting for the driver
    t_out_word expected_words[$];  // predicted words not yet seen at the output
    t_out_word step_words[$];      // words caused by the byte being parsed
    int        mismatch_count = 0;

    // ------------------------------------------------------------------
    // Parser shadow: register copies and parse state, at the block's widths
    // ------------------------------------------------------------------
    logic        cfg_mode      = 1'b0;
    logic [31:0] cfg_wanted    = '0;

    id3fte_pkg::t_phase prs_phase = id3fte_pkg::PH_TAG;
    logic [3:0]  prs_idx       = '0;   // byte position inside a 10-byte header
    logic [31:0] prs_id        = '0;
    logic [31:0] prs_size      = '0;   // syncsafe size in the tag header, plain in frames
    logic [23:0] prs_info      = '0;   // major, revision, flags
    logic [27:0] prs_tag_len   = '0;
    logic [31:0] prs_consumed  = '0;   // bytes taken after the tag header, saturating
    logic [31:0] prs_pay_left  = '0;
    logic        prs_match     = 1'b0; // extract mode: inside the wanted frame

    function automatic void emit(input id3fte_pkg::t_kind kind, input logic [31:0] fid,
                                 input logic [7:0] ch, input logic [23:0] info,
                                 input logic [27:0] sz);
        t_out_word w;
        if (step_words.size() >= id3fte_pkg::MaxResult) return;
        w.res.kind          = kind;
        w.res.frame_id      = fid;
        w.res.text_char     = ch;
        w.res.major_version = info[23:16];
        w.res.revision      = info[15:8];
        w.res.tag_flags     = info[7:0];
        w.res.tag_bytes     = sz;
        w.last              = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void bump_count(input logic [31:0] k);
        logic [32:0] sum;
        sum = {1'b0, prs_consumed} + {1'b0, k};
        prs_consumed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Tag is over: list mode says tag end, extract mode says not found.
    function automatic void close_tag();
        emit(cfg_mode ? id3fte_pkg::KIND_NOT_FOUND : id3fte_pkg::KIND_TAG_END,
             '0, '0, '0, '0);
        prs_phase = id3fte_pkg::PH_DONE;
    endfunction

    // Tag size is only looked at here, between frames.
    function automatic void next_frame_or_end();
        if (prs_consumed >= {4'h0, prs_tag_len}) begin
            close_tag();
        end else begin
            prs_phase = id3fte_pkg::PH_FHDR;
            prs_idx   = '0;
            prs_id    = '0;
            prs_size  = '0;
        end
    endfunction

    function automatic void close_frame();
        if (!cfg_mode || prs_match) emit(id3fte_pkg::KIND_FRM_END, '0, '0, '0, '0);
        if (prs_match) begin
            // wanted frame delivered, nothing more until a restart
            prs_match = 1'b0;
            prs_phase = id3fte_pkg::PH_DONE;
        end else begin
            next_frame_or_end();
        end
    endfunction

    // Advance the shadow parser by one accepted byte and queue its words.
    task automatic parse_byte(input logic [7:0] b, input logic start);
        logic [3:0] idx;
        logic       keep;
        t_out_word  w;
        step_words.delete();
        if (start) begin
            prs_phase    = id3fte_pkg::PH_TAG;
            prs_idx      = '0;
            prs_id       = '0;
            prs_size     = '0;
            prs_info     = '0;
            prs_tag_len  = '0;
            prs_consumed = '0;
            prs_pay_left = '0;
            prs_match    = 1'b0;
        end
        idx = prs_idx;
        case (prs_phase)
            id3fte_pkg::PH_TAG: begin
                // "ID3" marker bytes are taken without a check
                if (idx == 4'd0) begin
                    prs_info = '0;
                    prs_size = '0;
                end
                if (idx == 4'd3) prs_info = prs_info | {b, 16'h0000};
                else if (idx == 4'd4) prs_info = prs_info | {8'h00, b, 8'h00};
                else if (idx == 4'd5) prs_info = prs_info | {16'h0000, b};
                else if (idx >= 4'd6) prs_size = {4'h0, prs_size[20:0], b[6:0]};
                prs_idx = idx + 4'd1;
                if (idx >= id3fte_pkg::HdrLen - 1) begin
                    prs_tag_len  = prs_size[27:0];
                    prs_consumed = '0;
                    emit(id3fte_pkg::KIND_TAG_HDR, '0, '0, prs_info, prs_tag_len);
                    next_frame_or_end();
                end
            end
            id3fte_pkg::PH_FHDR: begin
                if (idx == 4'd0 && b == 8'h00) begin
                    // padding
                    bump_count(1);
                    close_tag();
                end else begin
                    if (idx < 4'd4) prs_id = {prs_id[23:0], b};
                    else if (idx < 4'd8) prs_size = {prs_size[23:0], b};
                    prs_idx = idx + 4'd1;
                    if (idx >= id3fte_pkg::HdrLen - 1) begin
                        bump_count(id3fte_pkg::HdrLen);
                        prs_pay_left = prs_size;
                        prs_match    = 1'b0;
                        if (!cfg_mode) begin
                            emit(id3fte_pkg::KIND_FRM_BEGIN, prs_id, '0, '0, '0);
                        end else if (prs_id == cfg_wanted) begin
                            prs_match = 1'b1;
                            emit(id3fte_pkg::KIND_FRM_BEGIN, prs_id, '0, '0, '0);
                        end
                        if (prs_pay_left == 0) close_frame();
                        else prs_phase = id3fte_pkg::PH_PAY;
                    end
                end
            end
            id3fte_pkg::PH_PAY: begin
                bump_count(1);
                if (prs_pay_left > 0) prs_pay_left = prs_pay_left - 1;
                keep = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                       (b >= "0" && b <= "9") || b == " " || b == "." ||
                       b == "/" || b == ",";
                if ((!cfg_mode || prs_match) && keep) begin
                    emit(id3fte_pkg::KIND_TEXT, '0, b, '0, '0);
                end
                if (prs_pay_left == 0) close_frame();
            end
            default: ;  // done: ignore until restart
        endcase
        if (step_words.size() != 0) begin
            w = step_words.pop_back();
            w.last = 1'b1;
            step_words.push_back(w);
        end
        foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void send(input logic [7:0] d, input logic s);
        t_in_word w;
        w.data  = d;
        w.start = s;
        pending_bytes.push_back(w);
    endfunction

    // 10-byte tag header; raw_size carries the four size bytes as sent.
    function automatic void send_header(input logic restart, input logic [23:0] marker,
                                        input logic [7:0] maj, input logic [7:0] rev,
                                        input logic [7:0] flg, input logic [31:0] raw_size);
        send(marker[23:16], restart);
        send(marker[15:8], 1'b0);
        send(marker[7:0], 1'b0);
        send(maj, 1'b0);
        send(rev, 1'b0);
        send(flg, 1'b0);
        for (int k = 3; k >= 0; k--) send(raw_size[8*k +: 8], 1'b0);
    endfunction

    function automatic void send_frame_hdr(input logic [31:0] id, input logic [31:0] size,
                                           input logic [15:0] flags);
        for (int k = 3; k >= 0; k--) send(id[8*k +: 8], 1'b0);
        for (int k = 3; k >= 0; k--) send(size[8*k +: 8], 1'b0);
        send(flags[15:8], 1'b0);
        send(flags[7:0], 1'b0);
    endfunction

    // A small well-formed tag with random content; hit_id shows up in about a
    // third of the frames. The tag size is exact, padded, short or huge.
    function automatic void queue_random_tag(input logic [31:0] hit_id);
        int          n_frames;
        int          frame_len [4];
        int          body_len;
        int          style;
        int          n_pad;
        logic [27:0] tsize;
        logic [31:0] raw;
        logic [31:0] id;
        n_frames = $urandom_range(0, 2);
        body_len = 0;
        for (int f = 0; f < n_frames; f++) begin
            frame_len[f] = $urandom_range(0, 4);
            body_len += id3fte_pkg::HdrLen + frame_len[f];
        end
        style = $urandom_range(0, 3);
        n_pad = 0;
        case (style)
            0: tsize = 28'(body_len);
            1: begin
                n_pad = $urandom_range(1, 3);
                tsize = 28'(body_len + n_pad + $urandom_range(0, 4));
            end
            2: tsize = (body_len > 0) ? 28'($urandom_range(0, body_len - 1)) : '0;
            default: begin
                // runs past the body: ends on padding, noise or the next restart
                tsize = 28'($urandom());
                n_pad = $urandom_range(0, 1);
            end
        endcase
        raw = {1'b0, tsize[27:21], 1'b0, tsize[20:14], 1'b0, tsize[13:7], 1'b0, tsize[6:0]};
        if ($urandom_range(0, 2) == 0) raw = raw | (32'h8080_8080 & $urandom());
        send_header(1'b1, ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'("ID3"),
                    8'($urandom()), 8'($urandom()), 8'($urandom()), raw);
        for (int f = 0; f < n_frames; f++) begin
            if (hit_id[31:24] != 8'h00 && $urandom_range(0, 2) == 0) begin
                id = hit_id;
            end else begin
                id = {($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                  : 8'($urandom_range(65, 90)),
                      8'($urandom_range(48, 90)), 8'($urandom()),
                      8'($urandom_range(48, 57))};
            end
            send_frame_hdr(id, 32'(frame_len[f]), 16'($urandom()));
            for (int p = 0; p < frame_len[f]; p++) begin
                send(($urandom_range(0, 1) == 0) ? 8'($urandom_range(32, 126))
                                                 : 8'($urandom()), 1'b0);
            end
        end
        for (int p = 0; p < n_pad; p++) send(8'h00, 1'b0);
        repeat ($urandom_range(0, 3)) send(8'($urandom()), 1'b0);
    endfunction

    // Registers are written only with nothing in flight.
    task automatic write_reg(input id3fte_pkg::t_cfg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == id3fte_pkg::CFG_MODE) cfg_mode = value[0];
        else cfg_wanted = value;
    endtask

    // Wait until every byte is taken and every word has come out, then let
    // trailing no-result bytes clear the pipeline.
    task automatic drain();
        while (pending_bytes.size() != 0 || i_in_valid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of bytes with random gaps; predicts on each handshake
    // ------------------------------------------------------------------
    t_in_word next_in;
    int       burst_left = 0;
    int       gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_data_byte, i_file_start);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    next_in = pending_bytes.pop_front();
                    i_in_valid   <= 1'b1;
                    i_data_byte  <= next_in.data;
                    i_file_start <= next_in.start;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted word; stall pattern rotates, driven by a free-running
    // counter, through none, alternate, light random and heavy random.
    // ------------------------------------------------------------------
    t_out_word  head_word;
    logic [7:0] stall_cyc = '0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                $display("%0t: word expected none, got kind %0d", $time, o_kind);
            end else begin
                head_word = expected_words.pop_front();
                compare_field("kind", head_word.res.kind, o_kind);
                compare_field("frame_id", head_word.res.frame_id, o_frame_id);
                compare_field("text_char", head_word.res.text_char, o_text_char);
                compare_field("major_version", head_word.res.major_version, o_major_version);
                compare_field("revision", head_word.res.revision, o_revision);
                compare_field("tag_flags", head_word.res.tag_flags, o_tag_flags);
                compare_field("tag_bytes", head_word.res.tag_bytes, o_tag_bytes);
                compare_field("last", head_word.last, o_last);
            end
        end
        stall_cyc <= stall_cyc + 8'd1;
        case (stall_cyc[7:6])
            2'd0:    i_out_stall <= 1'b0;
            2'd1:    i_out_stall <= stall_cyc[0];
            2'd2:    i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Watchdog: too long without any handshake means the block hung.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // List mode from reset. First tag has no restart flag; size bytes
        // carry top bits that must be dropped (size 12). The last payload byte
        // gives text, frame end and tag end together; a stray byte follows.
        send_header(1'b0, "ID3", 8'h04, 8'h00, 8'h00, 32'h8080_808C);
        send_frame_hdr("TIT2", 32'd2, 16'h0000);
        send(8'hFF, 1'b0);
        send("z", 1'b0);
        send("A", 1'b0);
        // empty tag: header and tag end on the same byte
        send_header(1'b1, "ID3", 8'hFF, 8'h00, 8'hFF, 32'h0000_0000);
        // largest tag size, an empty frame, then padding
        send_header(1'b1, "ID3", 8'h03, 8'hFF, 8'h00, 32'h7F7F_7F7F);
        send_frame_hdr(32'hFF00_0001, 32'd0, 16'hFFFF);
        send(8'h00, 1'b0);
        drain();

        // Extract mode, all-ones frame ID.
        write_reg(id3fte_pkg::CFG_MODE, 32'd1);
        write_reg(id3fte_pkg::CFG_WANTED_ID, 32'hFFFF_FFFF);
        @(negedge i_clk);
        queue_random_tag(32'hFFFF_FFFF);
        drain();

        // Switch to list mode inside a matched frame: its text still comes
        // out, then it ends and the tag is done.
        write_reg(id3fte_pkg::CFG_WANTED_ID, "TIT2");
        @(negedge i_clk);
        send_header(1'b1, "ID3", 8'h04, 8'h00, 8'h00, 32'h0000_0030);
        send_frame_hdr("TXXX", 32'd2, 16'h0000);
        send("a", 1'b0);
        send("b", 1'b0);
        send_frame_hdr("TIT2", 32'd4, 16'h0000);
        send("H", 1'b0);
        send("i", 1'b0);
        drain();
        write_reg(id3fte_pkg::CFG_MODE, 32'd0);
        @(negedge i_clk);
        send("!", 1'b0);
        send("x", 1'b0);
        send("Q", 1'b0);
        drain();

        // List mode, random tag.
        @(negedge i_clk);
        queue_random_tag("TIT2");
        drain();

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
